@@ sv/register_reply_frame_parser_macros.svh @@
// ----------------------------------------------------------------------------
// register reply frame parser assertion macros
// shared concurrent checks, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef REGISTER_REPLY_FRAME_PARSER_MACROS_SVH
`define REGISTER_REPLY_FRAME_PARSER_MACROS_SVH

// property that holds at every edge out of reset
`define RRFP_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RRFP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define RRFP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/rrfp_pkg.sv @@
// ----------------------------------------------------------------------------
// register reply frame parser package
// widths, phase encoding and result codes of the frame parser
// ----------------------------------------------------------------------------
`default_nettype none

package rrfp_pkg;

	localparam int MAX_PAYLOAD_BYTES = 64;
	localparam int SEEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
	localparam int BODY_W = 10;
	localparam int CMP_W = (SEEN_W > BODY_W) ? SEEN_W : BODY_W;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_READ_HEADER  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HEADER = 8'd1;

	localparam logic [7:0] READ_HEADER_RESET  = 8'd1;
	localparam logic [7:0] WRITE_HEADER_RESET = 8'd2;

	localparam logic [3:0] DEV_ERR_CHECKSUM = 4'd1;
	localparam logic [3:0] DEV_ERR_BAD_REG  = 4'd2;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_INDEX   = 3'd1,
		PH_COUNT   = 3'd2,
		PH_MAPERR  = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CHECK   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD   = 2'd0,
		KIND_COMPLETE  = 2'd1,
		KIND_MALFORMED = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_BAD_SUM    = 2'd1,
		STAT_DEV_SUM    = 2'd2,
		STAT_DEV_BAD_REG = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ sv/register_reply_frame_parser.sv @@
// ----------------------------------------------------------------------------
// register reply frame parser
// splits received serial bytes into read reply and write acknowledge frames
// ----------------------------------------------------------------------------
// usage:
// bytes enter on in_valid/in_ready with rx_byte. the parser hunts for a read
// or write header, takes index, count and map/error bytes, forwards each
// payload byte of a read frame as a payload beat, and closes every frame on
// its checksum byte with a complete beat carrying the frame status. a payload
// byte beyond the payload limit drops the frame with a malformed beat.
// results leave on out_valid/out_ready from one output register, in the cycle
// after the byte that caused them. one byte is taken every cycle; the single
// pass through the parser logic into the output register sets that figure.
// while a result waits the parser still takes a byte if the result is taken
// in the same cycle; a stalled receiver holds in_ready low until it drains.
// header codes are written on cfg_valid/cfg_ready with cfg_index and
// cfg_data, always ready; the user must write them only while the parser is
// idle, the block does not enforce it. reset returns the parser to hunting
// with header codes 1 (read) and 2 (write) and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_reply_frame_parser_macros.svh"

module register_reply_frame_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [rrfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [7:0]                     rx_byte,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [1:0]                          result_kind,
	output logic [7:0]                          payload_byte,
	output logic                                frame_is_read,
	output logic [7:0]                          reg_index,
	output logic [7:0]                          word_count,
	output logic [3:0]                          map_index,
	output logic [3:0]                          device_error,
	output logic [1:0]                          frame_status
);

	import rrfp_pkg::*;

	logic [7:0]        read_code_q;
	logic [7:0]        write_code_q;

	phase_t            phase_q, phase_nxt;
	logic              is_read_q, is_read_nxt;
	logic [7:0]        index_q, index_nxt;
	logic [7:0]        count_q, count_nxt;
	logic [3:0]        map_q, map_nxt;
	logic [3:0]        err_q, err_nxt;
	logic [SEEN_W-1:0] seen_q, seen_nxt;
	logic [7:0]        sum_q, sum_nxt;

	logic              in_acc;
	logic              res_valid;
	kind_t             res_kind;
	logic [7:0]        res_data;
	status_t           res_status;

	logic [7:0]        sum_add;
	logic [SEEN_W-1:0] seen_inc;
	logic [CMP_W-1:0]  body_ext;
	logic [CMP_W-1:0]  seen_ext;
	logic [CMP_W-1:0]  seen_inc_ext;
	logic              hdr_read;
	logic              hdr_write;

	logic              out_valid_q;
	kind_t             kind_q;
	logic [7:0]        data_q;
	logic              res_read_q;
	logic [7:0]        res_index_q;
	logic [7:0]        res_count_q;
	logic [3:0]        res_map_q;
	logic [3:0]        res_err_q;
	status_t           status_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;

	assign sum_add      = sum_q + rx_byte;
	assign seen_inc     = seen_q + 1'b1;
	assign body_ext     = CMP_W'({count_q, 2'b00});
	assign seen_ext     = CMP_W'(seen_q);
	assign seen_inc_ext = CMP_W'(seen_inc);
	assign hdr_read     = (rx_byte == read_code_q);
	assign hdr_write    = (rx_byte == write_code_q);

	// header codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_code_q  <= READ_HEADER_RESET;
			write_code_q <= WRITE_HEADER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_READ_HEADER) begin
				read_code_q <= cfg_data;
			end else if (cfg_index == CFG_WRITE_HEADER) begin
				write_code_q <= cfg_data;
			end
		end
	end

	// frame parsing, one byte per pass
	always_comb begin
		phase_nxt   = phase_q;
		is_read_nxt = is_read_q;
		index_nxt   = index_q;
		count_nxt   = count_q;
		map_nxt     = map_q;
		err_nxt     = err_q;
		seen_nxt    = seen_q;
		sum_nxt     = sum_q;
		res_valid   = 1'b0;
		res_kind    = KIND_PAYLOAD;
		res_data    = 8'd0;
		res_status  = STAT_OK;

		case (phase_q)
			PH_INDEX: begin
				index_nxt = rx_byte;
				sum_nxt   = sum_add;
				phase_nxt = PH_COUNT;
			end
			PH_COUNT: begin
				count_nxt = rx_byte;
				sum_nxt   = sum_add;
				phase_nxt = PH_MAPERR;
			end
			PH_MAPERR: begin
				map_nxt   = rx_byte[7:4];
				err_nxt   = rx_byte[3:0];
				sum_nxt   = sum_add;
				phase_nxt = is_read_q ? PH_PAYLOAD : PH_CHECK;
			end
			PH_PAYLOAD: begin
				res_valid = 1'b1;
				if (seen_q >= SEEN_W'(MAX_PAYLOAD_BYTES)) begin
					res_kind    = KIND_MALFORMED;
					phase_nxt   = PH_HUNT;
					is_read_nxt = 1'b0;
					index_nxt   = 8'd0;
					count_nxt   = 8'd0;
					map_nxt     = 4'd0;
					err_nxt     = 4'd0;
					seen_nxt    = '0;
					sum_nxt     = 8'd0;
				end else begin
					res_data = rx_byte;
					if (seen_ext < body_ext) begin
						sum_nxt = sum_add;
					end
					seen_nxt = seen_inc;
					if (seen_inc_ext >= body_ext) begin
						phase_nxt = PH_CHECK;
					end
				end
			end
			PH_CHECK: begin
				res_valid = 1'b1;
				res_kind  = KIND_COMPLETE;
				if (sum_add != 8'd0) begin
					res_status = STAT_BAD_SUM;
				end else if (err_q == DEV_ERR_CHECKSUM) begin
					res_status = STAT_DEV_SUM;
				end else if (err_q == DEV_ERR_BAD_REG) begin
					res_status = STAT_DEV_BAD_REG;
				end
				phase_nxt   = PH_HUNT;
				is_read_nxt = 1'b0;
				index_nxt   = 8'd0;
				count_nxt   = 8'd0;
				map_nxt     = 4'd0;
				err_nxt     = 4'd0;
				seen_nxt    = '0;
				sum_nxt     = 8'd0;
			end
			default: begin
				phase_nxt = PH_HUNT;
				if (hdr_read || hdr_write) begin
					phase_nxt   = PH_INDEX;
					is_read_nxt = hdr_read;
					index_nxt   = 8'd0;
					count_nxt   = 8'd0;
					map_nxt     = 4'd0;
					err_nxt     = 4'd0;
					seen_nxt    = '0;
					sum_nxt     = rx_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HUNT;
			is_read_q <= 1'b0;
			index_q   <= 8'd0;
			count_q   <= 8'd0;
			map_q     <= 4'd0;
			err_q     <= 4'd0;
			seen_q    <= '0;
			sum_q     <= 8'd0;
		end else if (in_acc) begin
			phase_q   <= phase_nxt;
			is_read_q <= is_read_nxt;
			index_q   <= index_nxt;
			count_q   <= count_nxt;
			map_q     <= map_nxt;
			err_q     <= err_nxt;
			seen_q    <= seen_nxt;
			sum_q     <= sum_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_valid) begin
			kind_q      <= res_kind;
			data_q      <= res_data;
			res_read_q  <= is_read_q;
			res_index_q <= index_q;
			res_count_q <= count_q;
			res_map_q   <= map_q;
			res_err_q   <= err_q;
			status_q    <= res_status;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = kind_q;
	assign payload_byte  = data_q;
	assign frame_is_read = res_read_q;
	assign reg_index     = res_index_q;
	assign word_count    = res_count_q;
	assign map_index     = res_map_q;
	assign device_error  = res_err_q;
	assign frame_status  = status_q;

	// checks
	`RRFP_ASSERT_SAME(a_payload_only_read, phase_q == PH_PAYLOAD, is_read_q,
		"payload phase in a write frame")
	`RRFP_ASSERT_ALWAYS(a_seen_limit, seen_q <= SEEN_W'(MAX_PAYLOAD_BYTES),
		"payload count beyond limit")
	`RRFP_ASSERT_SAME(a_status_only_complete, out_valid_q && kind_q != KIND_COMPLETE,
		status_q == STAT_OK, "status set on a non-complete beat")
	`RRFP_ASSERT_NEXT(a_end_to_hunt, in_acc && res_valid && res_kind != KIND_PAYLOAD,
		phase_q == PH_HUNT && sum_q == 8'd0 && seen_q == '0,
		"frame state not cleared after frame end")
	`RRFP_ASSERT_SAME(a_payload_beat_src, in_acc && res_valid && res_kind == KIND_PAYLOAD,
		phase_q == PH_PAYLOAD, "payload beat outside payload phase")

endmodule

`default_nettype wire

@@ tb/sv/register_reply_frame_parser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// register reply frame parser testbench
// feeds serial bytes through the parser and checks every result beat against
// a local frame predictor: a short directed script with the header and error
// cases, then random frames (well formed, bad checksum, broken and overflowing)
// under several header code settings, random stalls and back pressure
// ----------------------------------------------------------------------------
module register_reply_frame_parser_tb;

	import rrfp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 48;
	localparam int SETTLE_CYCLES = 4;
	localparam int END_CYCLES = 8;
	localparam int PHASE_ITEMS = 90;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic        is_read;
		logic [7:0]  idx;
		logic [7:0]  cnt;
		logic [3:0]  map;
		logic [3:0]  err;
		status_t     status;
	} reply_beat_t;

	typedef enum bit {ROW_BYTE, ROW_CFG} row_op_t;

	typedef struct packed {
		row_op_t              op;
		logic                 typed;
		logic [CFG_IDX_W-1:0] addr;
		logic [7:0]           val;
		reply_beat_t          want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [7:0]           rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           result_kind;
	logic [7:0]           payload_byte;
	logic                 frame_is_read;
	logic [7:0]           reg_index;
	logic [7:0]           word_count;
	logic [3:0]           map_index;
	logic [3:0]           device_error;
	logic [1:0]           frame_status;

	// predictor state
	logic [7:0]  code_read;
	logic [7:0]  code_write;
	phase_t      frame_phase;
	logic        frame_read;
	logic [7:0]  frame_index;
	logic [7:0]  frame_count;
	logic [3:0]  frame_map;
	logic [3:0]  frame_err;
	logic [10:0] body_taken;
	logic [7:0]  sum_acc;

	reply_beat_t expect_q[$];
	script_row_t script[$];

	bit steady;
	bit hold_req;
	int mismatches;
	int bytes_sent;
	int bytes_parsed;
	int n_payload;
	int n_complete;
	int n_malformed;
	int n_status[4];

	register_reply_frame_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_kind  (result_kind),
		.payload_byte (payload_byte),
		.frame_is_read(frame_is_read),
		.reg_index    (reg_index),
		.word_count   (word_count),
		.map_index    (map_index),
		.device_error (device_error),
		.frame_status (frame_status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_frame();
		frame_phase = PH_HUNT;
		frame_read = 1'b0;
		frame_index = 8'h00;
		frame_count = 8'h00;
		frame_map = 4'h0;
		frame_err = 4'h0;
		body_taken = 11'd0;
		sum_acc = 8'h00;
	endfunction

	function automatic reply_beat_t frame_beat(kind_t k, logic [7:0] d, status_t s);
		reply_beat_t r;
		r.kind = k;
		r.data = d;
		r.is_read = frame_read;
		r.idx = frame_index;
		r.cnt = frame_count;
		r.map = frame_map;
		r.err = frame_err;
		r.status = s;
		return r;
	endfunction

	// advances the frame state by one byte, returns 1 when a beat comes out
	function automatic bit parse_byte(input logic [7:0] b, output reply_beat_t r);
		logic [9:0] body;
		status_t st;
		body = {frame_count, 2'b00};
		r = '0;
		case (frame_phase)
			PH_INDEX: begin
				frame_index = b;
				sum_acc = sum_acc + b;
				frame_phase = PH_COUNT;
			end
			PH_COUNT: begin
				frame_count = b;
				sum_acc = sum_acc + b;
				frame_phase = PH_MAPERR;
			end
			PH_MAPERR: begin
				frame_map = b[7:4];
				frame_err = b[3:0];
				sum_acc = sum_acc + b;
				frame_phase = frame_read ? PH_PAYLOAD : PH_CHECK;
			end
			PH_PAYLOAD: begin
				if (body_taken >= 11'(MAX_PAYLOAD_BYTES)) begin
					r = frame_beat(KIND_MALFORMED, 8'h00, STAT_OK);
					clear_frame();
					return 1'b1;
				end
				// count zero still takes one byte, left out of the sum
				if (body_taken < 11'(body))
					sum_acc = sum_acc + b;
				body_taken = body_taken + 11'd1;
				if (body_taken >= 11'(body))
					frame_phase = PH_CHECK;
				r = frame_beat(KIND_PAYLOAD, b, STAT_OK);
				return 1'b1;
			end
			PH_CHECK: begin
				sum_acc = sum_acc + b;
				if (sum_acc != 8'h00)
					st = STAT_BAD_SUM;
				else if (frame_err == DEV_ERR_CHECKSUM)
					st = STAT_DEV_SUM;
				else if (frame_err == DEV_ERR_BAD_REG)
					st = STAT_DEV_BAD_REG;
				else
					st = STAT_OK;
				r = frame_beat(KIND_COMPLETE, 8'h00, st);
				clear_frame();
				return 1'b1;
			end
			default: begin
				// read code wins when both codes match
				if (b == code_read || b == code_write) begin
					clear_frame();
					frame_read = (b == code_read);
					sum_acc = b;
					frame_phase = PH_INDEX;
				end else begin
					frame_phase = PH_HUNT;
				end
			end
		endcase
		return 1'b0;
	endfunction

	function automatic reply_beat_t typed_beat(kind_t k, logic [7:0] d, logic rd,
			logic [7:0] ix, logic [7:0] cn, logic [3:0] mp, logic [3:0] er, status_t s);
		reply_beat_t r;
		r.kind = k;
		r.data = d;
		r.is_read = rd;
		r.idx = ix;
		r.cnt = cn;
		r.map = mp;
		r.err = er;
		r.status = s;
		return r;
	endfunction

	function automatic void add_row(row_op_t op, logic [CFG_IDX_W-1:0] addr, logic [7:0] val,
			logic typed, reply_beat_t want);
		script_row_t r;
		r.op = op;
		r.typed = typed;
		r.addr = addr;
		r.val = val;
		r.want = want;
		script.push_back(r);
	endfunction

	function automatic void cfg_row(logic [CFG_IDX_W-1:0] addr, logic [7:0] val);
		add_row(ROW_CFG, addr, val, 1'b0, '0);
	endfunction

	function automatic void byte_row(logic [7:0] val);
		add_row(ROW_BYTE, '0, val, 1'b0, '0);
	endfunction

	function automatic void want_row(logic [7:0] val, reply_beat_t want);
		add_row(ROW_BYTE, '0, val, 1'b1, want);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic typed, input reply_beat_t want);
		reply_beat_t got;
		if (!steady)
			while ($urandom_range(0, 99) < 25) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		if (frame_phase != PH_HUNT || b == code_read || b == code_write)
			bytes_parsed++;
		if (parse_byte(b, got))
			expect_q.push_back(typed ? want : got);
	endtask

	// header codes change only with no beat in flight
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		in_valid <= 1'b0;
		do @(posedge clk); while (expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_READ_HEADER: code_read = val;
			CFG_WRITE_HEADER: code_write = val;
			default: ;
		endcase
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// result checker
	initial begin
		reply_beat_t got;
		reply_beat_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.kind = kind_t'(result_kind);
				got.data = payload_byte;
				got.is_read = frame_is_read;
				got.idx = reg_index;
				got.cnt = word_count;
				got.map = map_index;
				got.err = device_error;
				got.status = status_t'(frame_status);
				case (got.kind)
					KIND_PAYLOAD: n_payload++;
					KIND_COMPLETE: begin
						n_complete++;
						n_status[frame_status]++;
					end
					default: n_malformed++;
				endcase
				if (expect_q.size() == 0) begin
					mismatches++;
					$display("%0t: result beat expected none, got kind %0d data %0h",
						$time, result_kind, payload_byte);
				end else begin
					want = expect_q.pop_front();
					check_field("result_kind", 8'(want.kind), 8'(got.kind));
					check_field("payload_byte", want.data, got.data);
					check_field("frame_is_read", 8'(want.is_read), 8'(got.is_read));
					check_field("reg_index", want.idx, got.idx);
					check_field("word_count", want.cnt, got.cnt);
					check_field("map_index", 8'(want.map), 8'(got.map));
					check_field("device_error", 8'(want.err), 8'(got.err));
					check_field("frame_status", 8'(want.status), 8'(got.status));
				end
			end
		end
	end

	// watchdog
	initial begin
		int stall_cycles;
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [7:0] rd;
		logic [7:0] wr;
		logic [7:0] hdr;
		logic [7:0] idx;
		logic [7:0] cnt;
		logic [7:0] me;
		logic [7:0] sum;
		logic [7:0] p;
		logic [7:0] frame_q[$];
		bit as_read;
		bit paused;
		int pick;
		int n;
		int goal;

		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = 8'h00;
		steady = 1'b0;
		hold_req = 1'b0;
		paused = 1'b0;
		code_read = READ_HEADER_RESET;
		code_write = WRITE_HEADER_RESET;
		clear_frame();

		// index outside the register map leaves the codes alone
		cfg_row(CFG_UNMAPPED, 8'h55);
		byte_row(8'h00);
		byte_row(8'hFF);
		// write ack, extreme fields, device error outside 1 and 2
		byte_row(8'h02);
		byte_row(8'hFF);
		byte_row(8'h00);
		byte_row(8'hFF);
		want_row(8'h00, typed_beat(KIND_COMPLETE, 8'h00, 1'b0, 8'hFF, 8'h00, 4'hF, 4'hF,
			STAT_OK));
		// read with count zero, device checksum error
		byte_row(8'h01);
		byte_row(8'h00);
		byte_row(8'h00);
		byte_row(8'h01);
		byte_row(8'hAB);
		want_row(8'hFE, typed_beat(KIND_COMPLETE, 8'h00, 1'b1, 8'h00, 8'h00, 4'h0, 4'h1,
			STAT_DEV_SUM));
		// bad local sum beats device error
		byte_row(8'h02);
		byte_row(8'h80);
		byte_row(8'h7F);
		byte_row(8'h02);
		want_row(8'h55, typed_beat(KIND_COMPLETE, 8'h00, 1'b0, 8'h80, 8'h7F, 4'h0, 4'h2,
			STAT_BAD_SUM));
		// equal codes start a read
		cfg_row(CFG_READ_HEADER, 8'h80);
		cfg_row(CFG_WRITE_HEADER, 8'h80);
		byte_row(8'h80);
		byte_row(8'h05);
		byte_row(8'h00);
		byte_row(8'h32);
		byte_row(8'hEE);
		want_row(8'h49, typed_beat(KIND_COMPLETE, 8'h00, 1'b1, 8'h05, 8'h00, 4'h3, 4'h2,
			STAT_DEV_BAD_REG));
		// codes change after the header, frame stays a read
		byte_row(8'h80);
		cfg_row(CFG_READ_HEADER, 8'h00);
		cfg_row(CFG_WRITE_HEADER, 8'hFF);
		byte_row(8'h11);
		byte_row(8'h00);
		byte_row(8'h40);
		byte_row(8'h77);
		byte_row(8'h2F);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (script[i]) begin
			if (script[i].op == ROW_CFG)
				write_reg(script[i].addr, script[i].val);
			else
				send_byte(script[i].val, script[i].typed, script[i].want);
		end

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin
					rd = 8'hFF;
					wr = 8'h00;
				end
				2: begin
					rd = 8'($urandom);
					wr = rd;
				end
				3: begin
					rd = READ_HEADER_RESET;
					wr = WRITE_HEADER_RESET;
				end
				default: begin
					rd = 8'($urandom);
					wr = 8'($urandom);
				end
			endcase
			steady = (ph == 3);
			write_reg(CFG_READ_HEADER, rd);
			write_reg(CFG_WRITE_HEADER, wr);
			write_reg(8'($urandom_range(2, 255)), 8'($urandom));
			// receiver stalls while bytes keep coming
			if (ph == 1)
				hold_req = 1'b1;
			goal = bytes_parsed + PHASE_ITEMS;
			while (bytes_parsed < goal) begin
				if (ph == 2 && !paused && bytes_parsed > goal - PHASE_ITEMS / 2) begin
					paused = 1'b1;
					in_valid <= 1'b0;
					do @(posedge clk); while (expect_q.size() != 0);
				end
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					// line noise
					n = $urandom_range(1, 3);
					repeat (n) frame_q.push_back(8'($urandom));
				end else if (pick < 14) begin
					// header followed by a cut-off frame
					frame_q.push_back($urandom_range(0, 1) ? code_read : code_write);
					n = $urandom_range(0, 3);
					repeat (n) frame_q.push_back(8'($urandom));
				end else if (pick < 18) begin
					// payload runs past the limit
					frame_q.push_back(code_read);
					frame_q.push_back(8'($urandom));
					frame_q.push_back(8'($urandom_range(17, 255)));
					frame_q.push_back(8'($urandom));
					repeat (MAX_PAYLOAD_BYTES + 1) frame_q.push_back(8'($urandom));
				end else begin
					as_read = $urandom_range(0, 1);
					hdr = as_read ? code_read : code_write;
					as_read = (hdr == code_read);
					idx = 8'($urandom);
					if (as_read) begin
						n = $urandom_range(0, 99);
						if (n < 80)
							cnt = 8'($urandom_range(0, 3));
						else if (n < 95)
							cnt = 8'($urandom_range(4, 15));
						else
							cnt = 8'(MAX_PAYLOAD_BYTES / 4);
					end else begin
						cnt = 8'($urandom);
					end
					me[7:4] = 4'($urandom);
					me[3:0] = ($urandom_range(0, 99) < 50) ? 4'($urandom_range(0, 2))
						: 4'($urandom);
					sum = hdr + idx + cnt + me;
					frame_q.push_back(hdr);
					frame_q.push_back(idx);
					frame_q.push_back(cnt);
					frame_q.push_back(me);
					if (as_read) begin
						n = (cnt == 8'h00) ? 1 : 4 * int'(cnt);
						repeat (n) begin
							p = 8'($urandom);
							frame_q.push_back(p);
							if (cnt != 8'h00)
								sum = sum + p;
						end
					end
					sum = -sum;
					if ($urandom_range(0, 99) < 15)
						sum = sum + 8'($urandom_range(1, 255));
					frame_q.push_back(sum);
				end
				foreach (frame_q[i])
					send_byte(frame_q[i], 1'b0, '0);
				frame_q.delete();
			end
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		do @(posedge clk); while (expect_q.size() != 0);
		repeat (END_CYCLES) @(posedge clk);

		$display("%0d bytes sent: %0d payload beats, %0d closed frames, %0d malformed drops",
			bytes_sent, n_payload, n_complete, n_malformed);
		$display("closing status: %0d ok, %0d bad sum, %0d device sum, %0d bad register",
			n_status[0], n_status[1], n_status[2], n_status[3]);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+sv
sv/rrfp_pkg.sv
sv/register_reply_frame_parser.sv
tb/sv/register_reply_frame_parser_tb.sv
